FILE: sv/jic_pkg.sv
// ----------------------------------------------------------------------------
// jic_pkg
// shared types and constants of the joystick input conditioner
// ----------------------------------------------------------------------------
package jic_pkg;

  localparam int unsigned AxisW   = 12;
  localparam int unsigned OffsW   = AxisW + 1;
  localparam int unsigned DzW     = 11;
  localparam int unsigned DzSqW   = 2 * DzW;
  localparam int unsigned BtnW    = 4;
  localparam int unsigned CountW  = 8;
  localparam int unsigned SectW   = 3;
  localparam int unsigned IdleW   = 2;

  localparam logic [AxisW-1:0]  AxisMid   = 12'd2048;
  localparam logic [DzW-1:0]    DzReset   = 11'd800;
  localparam logic [CountW-1:0] CountMax  = 8'd255;
  localparam logic [IdleW-1:0]  IdleMax   = 2'd3;
  localparam logic [IdleW-1:0]  IdleLimit = 2'd2;

  // register indexes on the configuration port
  localparam logic [1:0] RegCenterX  = 2'd0;
  localparam logic [1:0] RegCenterY  = 2'd1;
  localparam logic [1:0] RegDeadzone = 2'd2;

  // item kinds
  localparam logic OpFrame = 1'b0;
  localparam logic OpTake  = 1'b1;

  // sectors, numbered clockwise from the right in screen terms
  localparam logic [SectW-1:0] SectRight     = 3'd0;
  localparam logic [SectW-1:0] SectDownRight = 3'd1;
  localparam logic [SectW-1:0] SectDownNear  = 3'd2;
  localparam logic [SectW-1:0] SectDownLeft  = 3'd3;
  localparam logic [SectW-1:0] SectLeftLow   = 3'd4;
  localparam logic [SectW-1:0] SectLeftHigh  = 3'd5;
  localparam logic [SectW-1:0] SectUpLeft    = 3'd6;
  localparam logic [SectW-1:0] SectUpRight   = 3'd7;

  // clockwise steps that count as one pulse
  localparam logic [SectW-1:0] StepOne = 3'd1;
  localparam logic [SectW-1:0] StepTwo = 3'd2;

  // item after smoothing, on its way to the sector stage
  typedef struct packed {
    logic                     opcode;
    logic signed [OffsW-1:0]  dx;
    logic signed [OffsW-1:0]  dy;
  } stage1_t;

  // per-item result of the sector stage
  typedef struct packed {
    logic [BtnW-1:0]   dir;
    logic              taken;
    logic [CountW-1:0] pending;
  } sect_res_t;

endpackage

FILE: sv/jic_cfg.sv
// ----------------------------------------------------------------------------
// jic_cfg
// configuration registers behind the register port, with deadzone square
// ----------------------------------------------------------------------------
module jic_cfg (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     psel,
  input  logic                     penable,
  input  logic                     pwrite,
  input  logic [3:0]               paddr,
  input  logic [31:0]              pwdata,
  output logic [31:0]              prdata,
  output logic                     pready,
  output logic [jic_pkg::AxisW-1:0] center_x_o,
  output logic [jic_pkg::AxisW-1:0] center_y_o,
  output logic [jic_pkg::DzW-1:0]   deadzone_o,
  output logic [jic_pkg::DzSqW-1:0] dz_sq_o
);
  import jic_pkg::*;

  logic [AxisW-1:0] center_x_q;
  logic [AxisW-1:0] center_y_q;
  logic [DzW-1:0]   deadzone_q;
  logic [DzSqW-1:0] dz_sq_q;
  logic [1:0]       idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_x_q <= AxisMid;
      center_y_q <= AxisMid;
      deadzone_q <= DzReset;
    end else if (wr_en) begin
      case (idx)
        RegCenterX:  center_x_q <= pwdata[AxisW-1:0];
        RegCenterY:  center_y_q <= pwdata[AxisW-1:0];
        RegDeadzone: deadzone_q <= pwdata[DzW-1:0];
        default: ;
      endcase
    end
  end

  // squared deadzone is registered from the deadzone register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dz_sq_q <= DzSqW'(DzReset) * DzSqW'(DzReset);
    end else begin
      dz_sq_q <= DzSqW'(deadzone_q) * DzSqW'(deadzone_q);
    end
  end

  always_comb begin
    prdata = '0;
    case (idx)
      RegCenterX:  prdata = {{(32-AxisW){1'b0}}, center_x_q};
      RegCenterY:  prdata = {{(32-AxisW){1'b0}}, center_y_q};
      RegDeadzone: prdata = {{(32-DzW){1'b0}}, deadzone_q};
      default:     prdata = '0;
    endcase
  end

  assign center_x_o = center_x_q;
  assign center_y_o = center_y_q;
  assign deadzone_o = deadzone_q;
  assign dz_sq_o    = dz_sq_q;

endmodule

FILE: sv/jic_smooth.sv
// ----------------------------------------------------------------------------
// jic_smooth
// axis smoothing, center offsets and button edge detection
// ----------------------------------------------------------------------------
module jic_smooth (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      en_i,
  input  logic                      opcode_i,
  input  logic [jic_pkg::AxisW-1:0] raw_x_i,
  input  logic [jic_pkg::AxisW-1:0] raw_y_i,
  input  logic [jic_pkg::BtnW-1:0]  btn_i,
  input  logic                      sw_i,
  input  logic [jic_pkg::AxisW-1:0] center_x_i,
  input  logic [jic_pkg::AxisW-1:0] center_y_i,
  output jic_pkg::stage1_t          p1_o,
  output logic [jic_pkg::AxisW-1:0] filt_x_o,
  output logic [jic_pkg::AxisW-1:0] filt_y_o,
  output logic [jic_pkg::BtnW-1:0]  pressed_o,
  output logic [jic_pkg::BtnW-1:0]  new_press_o,
  output logic                      switch_o
);
  import jic_pkg::*;

  logic [AxisW-1:0] smooth_x_q, smooth_x_d;
  logic [AxisW-1:0] smooth_y_q, smooth_y_d;
  logic [BtnW-1:0]  button_q;
  logic [BtnW-1:0]  edge_q;
  logic             switch_q;
  logic [AxisW+1:0] sum_x, sum_y;
  stage1_t          p1_q, p1_d;
  logic             frame;

  assign frame = (opcode_i == OpFrame);

  // 3*old + new fits in two extra bits
  assign sum_x = (AxisW+2)'(smooth_x_q) * (AxisW+2)'(3) + (AxisW+2)'(raw_x_i);
  assign sum_y = (AxisW+2)'(smooth_y_q) * (AxisW+2)'(3) + (AxisW+2)'(raw_y_i);
  assign smooth_x_d = frame ? sum_x[AxisW+1:2] : smooth_x_q;
  assign smooth_y_d = frame ? sum_y[AxisW+1:2] : smooth_y_q;

  always_comb begin
    p1_d.opcode = opcode_i;
    p1_d.dx     = $signed({1'b0, smooth_x_d}) - $signed({1'b0, center_x_i});
    p1_d.dy     = $signed({1'b0, smooth_y_d}) - $signed({1'b0, center_y_i});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smooth_x_q <= AxisMid;
      smooth_y_q <= AxisMid;
      button_q   <= '0;
      edge_q     <= '0;
      switch_q   <= 1'b0;
    end else if (en_i && frame) begin
      smooth_x_q <= smooth_x_d;
      smooth_y_q <= smooth_y_d;
      button_q   <= btn_i;
      edge_q     <= btn_i & ~button_q;
      switch_q   <= sw_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p1_q <= p1_d;
    end
  end

  assign p1_o        = p1_q;
  assign filt_x_o    = smooth_x_q;
  assign filt_y_o    = smooth_y_q;
  assign pressed_o   = button_q;
  assign new_press_o = edge_q;
  assign switch_o    = switch_q;

endmodule

FILE: sv/jic_sector.sv
// ----------------------------------------------------------------------------
// jic_sector
// direction flags, deadzone test, sector tracking and pulse counter
// ----------------------------------------------------------------------------
module jic_sector (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       en_i,
  input  jic_pkg::stage1_t           p1_i,
  input  logic [jic_pkg::DzW-1:0]    deadzone_i,
  input  logic [jic_pkg::DzSqW-1:0]  dz_sq_i,
  output jic_pkg::sect_res_t         res_o
);
  import jic_pkg::*;

  logic [BtnW-1:0]   dir_q, dir_d;
  logic [SectW-1:0]  last_q, last_d;
  logic              valid_q, valid_d;
  logic [CountW-1:0] count_q, count_d;
  logic [IdleW-1:0]  idle_q, idle_d;
  logic              taken;

  logic signed [OffsW:0] dx_w, dy_w, dz_w, sum_w;
  logic [AxisW-1:0]      mag_x, mag_y;
  logic [2*AxisW-1:0]    sq_x, sq_y;
  logic [2*AxisW:0]      rad_sq;
  logic                  outside;
  logic [SectW-1:0]      sect, diff;
  logic [IdleW-1:0]      idle_inc;

  always_comb begin
    dx_w  = {p1_i.dx[OffsW-1], p1_i.dx};
    dy_w  = {p1_i.dy[OffsW-1], p1_i.dy};
    dz_w  = $signed({3'b000, deadzone_i});
    sum_w = dx_w + dy_w;
    mag_x = p1_i.dx[OffsW-1] ? AxisW'(-p1_i.dx) : p1_i.dx[AxisW-1:0];
    mag_y = p1_i.dy[OffsW-1] ? AxisW'(-p1_i.dy) : p1_i.dy[AxisW-1:0];
    sq_x  = mag_x * mag_x;
    sq_y  = mag_y * mag_y;
    rad_sq  = {1'b0, sq_x} + {1'b0, sq_y};
    outside = rad_sq > (2*AxisW+1)'(dz_sq_i);

    // ties follow the fixed quadrant rules
    if (dx_w > 0 && dy_w <= 0) begin
      sect = (sum_w < 0) ? SectUpRight : SectRight;
    end else if (dx_w > 0) begin
      sect = (dy_w > dx_w) ? SectDownNear : SectDownRight;
    end else if (dy_w > 0) begin
      sect = (sum_w > 0) ? SectDownLeft : SectLeftLow;
    end else begin
      sect = (dx_w > dy_w) ? SectUpLeft : SectLeftHigh;
    end
    diff     = sect - last_q;
    idle_inc = (idle_q < IdleMax) ? idle_q + 2'd1 : idle_q;

    dir_d   = dir_q;
    last_d  = last_q;
    valid_d = valid_q;
    count_d = count_q;
    idle_d  = idle_q;
    taken   = 1'b0;

    if (p1_i.opcode == OpFrame) begin
      dir_d = {dy_w > dz_w, dy_w < -dz_w, dx_w > dz_w, dx_w < -dz_w};
      if (outside) begin
        if (valid_q && (diff == StepOne || diff == StepTwo) && count_q != CountMax) begin
          count_d = count_q + 8'd1;
        end
        last_d  = sect;
        valid_d = 1'b1;
        idle_d  = '0;
      end else begin
        idle_d = idle_inc;
        if (idle_inc > IdleLimit) begin
          valid_d = 1'b0;
        end
      end
    end else if (count_q != '0) begin
      count_d = count_q - 8'd1;
      taken   = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dir_q   <= '0;
      last_q  <= SectRight;
      valid_q <= 1'b0;
      count_q <= '0;
      idle_q  <= '0;
    end else if (en_i) begin
      dir_q   <= dir_d;
      last_q  <= last_d;
      valid_q <= valid_d;
      count_q <= count_d;
      idle_q  <= idle_d;
    end
  end

  assign res_o.dir     = dir_d;
  assign res_o.taken   = taken;
  assign res_o.pending = count_d;

endmodule

FILE: sv/joystick_input_conditioner_core.sv
// ----------------------------------------------------------------------------
// joystick_input_conditioner_core
// joystick smoothing, deadzone, button edges and clockwise pulse counting
// ----------------------------------------------------------------------------
// Takes one transaction per clock on the input stream while not stalled and
// returns exactly one result transaction for each, in order. tuser selects the
// kind: a frame sample smooths both axes ((3*old+new)/4), subtracts the
// center, sets the direction flags, flags new button presses and, outside the
// circular deadzone, tracks the eight-way sector and counts clockwise steps
// of one or two sectors (saturating at 255); a take transaction consumes one
// pulse if one is pending. The block runs at one transaction per cycle, unless
// stalled, through two register stages: the first holds the smoothed axes
// and center offsets, the second evaluates the deadzone square and the sector
// into the output register. A transaction in stage one moves on once the
// output register is free. Back-pressure holds the output register, and the
// input stalls only once stage one is occupied as well, so at most two
// transactions are in flight. The user must write center and deadzone over
// the register port only while no transaction is in flight; the block does not
// enforce it. The squared deadzone is refreshed in the cycle after a write.
// ----------------------------------------------------------------------------
module joystick_input_conditioner_core (
  input  logic        clk_i,
  input  logic        rst_ni,

  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [11:0] raw_x, [23:12] raw_y, [27:24] button_levels, [28] stick_switch
  input  logic [31:0] s_axis_tdata,
  // [0] opcode
  input  logic        s_axis_tuser,

  // result stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [3:0] direction_flags, [7:4] pressed_flags, [11:8] new_press_flags,
  // [12] switch_pressed, [13] pulse_taken, [21:14] pulses_pending,
  // [33:22] filtered_x, [45:34] filtered_y
  output logic [47:0] m_axis_tdata,

  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import jic_pkg::*;

  logic [AxisW-1:0] center_x, center_y;
  logic [DzW-1:0]   deadzone;
  logic [DzSqW-1:0] dz_sq;

  stage1_t          p1;
  sect_res_t        res;
  logic [AxisW-1:0] filt_x, filt_y;
  logic [BtnW-1:0]  pressed, new_press;
  logic             switch_st;

  logic             v1_q;
  logic             out_valid_q;
  logic [47:0]      out_data_q;
  logic             adv_out, adv_in, accept;

  // output stage moves when empty or taken; input stage when stage one frees
  assign adv_out = !out_valid_q || m_axis_tready;
  assign adv_in  = !v1_q || adv_out;
  assign accept  = s_axis_tvalid && adv_in;
  assign s_axis_tready = adv_in;

  jic_cfg u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .center_x_o (center_x),
    .center_y_o (center_y),
    .deadzone_o (deadzone),
    .dz_sq_o    (dz_sq)
  );

  // stage one: smoothing, offsets and buttons
  jic_smooth u_smooth (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .en_i        (accept),
    .opcode_i    (s_axis_tuser),
    .raw_x_i     (s_axis_tdata[11:0]),
    .raw_y_i     (s_axis_tdata[23:12]),
    .btn_i       (s_axis_tdata[27:24]),
    .sw_i        (s_axis_tdata[28]),
    .center_x_i  (center_x),
    .center_y_i  (center_y),
    .p1_o        (p1),
    .filt_x_o    (filt_x),
    .filt_y_o    (filt_y),
    .pressed_o   (pressed),
    .new_press_o (new_press),
    .switch_o    (switch_st)
  );

  // stage two: direction flags, sector tracking and pulse count
  jic_sector u_sector (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .en_i       (v1_q && adv_out),
    .p1_i       (p1),
    .deadzone_i (deadzone),
    .dz_sq_i    (dz_sq),
    .res_o      (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (adv_in) begin
        v1_q <= s_axis_tvalid;
      end
      if (adv_out) begin
        out_valid_q <= v1_q;
      end
    end
  end

  // stage-one state still belongs to the item leaving it at this edge
  always_ff @(posedge clk_i) begin
    if (adv_out && v1_q) begin
      out_data_q <= {2'b00, filt_y, filt_x, res.pending, res.taken,
                     switch_st, new_press, pressed, res.dir};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

FILE: dv/tb_joystick_input_conditioner_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_joystick_input_conditioner_core
// self-checking bench for the joystick smoothing and pulse counting core
// ----------------------------------------------------------------------------
// Drives frame and take transactions into the input stream and keeps its own
// copy of the smoothing, deadzone, button and sector state. Every result
// transaction is checked field by field against the oldest prediction.
// Stimulus runs from a directed opening through a pulse saturation sweep,
// extreme register settings and mixed random traffic. Random idling on both
// streams and one long output stall push the core into back-pressure.
// ----------------------------------------------------------------------------
module tb_joystick_input_conditioner_core;
  import jic_pkg::*;

  localparam int CycleLimit  = 400000;
  localparam int DrainCycles = 6;
  localparam int HoldCycles  = 300;
  // register slot past the last one, writes there must be dropped
  localparam logic [1:0] RegUnused = 2'd3;

  // one result transaction, packed in tdata order (lowest field last)
  typedef struct packed {
    logic [AxisW-1:0]  filt_y;
    logic [AxisW-1:0]  filt_x;
    logic [CountW-1:0] pending;
    logic              taken;
    logic              sw;
    logic [BtnW-1:0]   new_press;
    logic [BtnW-1:0]   pressed;
    logic [BtnW-1:0]   dir;
  } cond_result_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic        s_axis_tuser = OpFrame;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [3:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  joystick_input_conditioner_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  // predictor copy of the registers and the conditioning state
  logic [AxisW-1:0]  cfg_cx = AxisMid;
  logic [AxisW-1:0]  cfg_cy = AxisMid;
  logic [DzW-1:0]    cfg_dz = DzReset;
  logic [AxisW-1:0]  sm_x = AxisMid;
  logic [AxisW-1:0]  sm_y = AxisMid;
  logic [BtnW-1:0]   dir_q = '0;
  logic [BtnW-1:0]   btn_q = '0;
  logic [BtnW-1:0]   press_edge_q = '0;
  logic              sw_q = 1'b0;
  logic [SectW-1:0]  sect_q = SectRight;
  logic              sect_known = 1'b0;
  logic [CountW-1:0] pulses = '0;
  logic [IdleW-1:0]  rest_frames = '0;

  cond_result_t awaited_results[$];
  int errors = 0;
  int items_sent = 0;
  int cycle_count = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_left = 0;

  // clock
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side ready: a long hold-off wins over the random idling
  always @(posedge clk_i) begin
    if (hold_left != 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // sector numbering, clockwise from the right with positive dy pointing down
  function automatic logic [SectW-1:0] stick_sector(int dx, int dy);
    if (dx > 0 && dy <= 0) return (-dy > dx) ? SectUpRight : SectRight;
    if (dx > 0 && dy > 0) return (dy > dx) ? SectDownNear : SectDownRight;
    if (dx <= 0 && dy > 0) return (dy > -dx) ? SectDownLeft : SectLeftLow;
    return (-dy > -dx) ? SectUpLeft : SectLeftHigh;
  endfunction

  // advance the predicted state by one accepted transaction
  function automatic cond_result_t condition_item(logic op, logic [AxisW-1:0] rx,
                                                  logic [AxisW-1:0] ry,
                                                  logic [BtnW-1:0] btn, logic sw);
    cond_result_t res;
    int dx;
    int dy;
    int dz;
    longint dist_sq;
    logic [SectW-1:0] sect;
    logic [SectW-1:0] turn;
    logic taken;
    taken = 1'b0;
    if (op == OpFrame) begin
      sm_x = AxisW'((int'(sm_x) * 3 + int'(rx)) >> 2);
      sm_y = AxisW'((int'(sm_y) * 3 + int'(ry)) >> 2);
      dx = int'(sm_x) - int'(cfg_cx);
      dy = int'(sm_y) - int'(cfg_cy);
      dz = int'(cfg_dz);
      dir_q = {dy > dz, dy < -dz, dx > dz, dx < -dz};
      press_edge_q = btn & ~btn_q;
      btn_q = btn;
      sw_q = sw;
      dist_sq = longint'(dx) * dx + longint'(dy) * dy;
      if (dist_sq > longint'(dz) * dz) begin
        sect = stick_sector(dx, dy);
        turn = sect - sect_q;
        // one or two sectors clockwise earns a pulse, saturating
        if (sect_known && (turn == StepOne || turn == StepTwo) && pulses != CountMax)
          pulses = pulses + 1'b1;
        sect_q = sect;
        sect_known = 1'b1;
        rest_frames = '0;
      end else begin
        if (rest_frames != IdleMax) rest_frames = rest_frames + 1'b1;
        // long enough at rest: forget where the stick was
        if (rest_frames > IdleLimit) sect_known = 1'b0;
      end
    end else if (pulses != 0) begin
      pulses = pulses - 1'b1;
      taken = 1'b1;
    end
    res.dir = dir_q;
    res.pressed = btn_q;
    res.new_press = press_edge_q;
    res.sw = sw_q;
    res.taken = taken;
    res.pending = pulses;
    res.filt_x = sm_x;
    res.filt_y = sm_y;
    return res;
  endfunction

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v !== act_v) begin
      errors++;
      $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
    end
  endtask

  // result checker, oldest prediction first
  always @(posedge clk_i) begin
    cond_result_t got;
    cond_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata[45:0];
      if (awaited_results.size() == 0) begin
        errors++;
        $display("%0t: result expected none actual %0h", $time, m_axis_tdata);
      end else begin
        want = awaited_results.pop_front();
        check_field("direction_flags", 32'(want.dir), 32'(got.dir));
        check_field("pressed_flags", 32'(want.pressed), 32'(got.pressed));
        check_field("new_press_flags", 32'(want.new_press), 32'(got.new_press));
        check_field("switch_pressed", 32'(want.sw), 32'(got.sw));
        check_field("pulse_taken", 32'(want.taken), 32'(got.taken));
        check_field("pulses_pending", 32'(want.pending), 32'(got.pending));
        check_field("filtered_x", 32'(want.filt_x), 32'(got.filt_x));
        check_field("filtered_y", 32'(want.filt_y), 32'(got.filt_y));
      end
    end
  end

  // one input transaction, with a random gap ahead of it
  task automatic send_item(logic op, logic [AxisW-1:0] rx, logic [AxisW-1:0] ry,
                           logic [BtnW-1:0] btn, logic sw);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {3'b000, sw, btn, ry, rx};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    awaited_results.push_back(condition_item(op, rx, ry, btn, sw));
    items_sent++;
  endtask

  // let every result come out before touching the registers
  task automatic settle_block();
    s_axis_tvalid <= 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      RegCenterX:  cfg_cx = value[AxisW-1:0];
      RegCenterY:  cfg_cy = value[AxisW-1:0];
      RegDeadzone: cfg_dz = value[DzW-1:0];
      default: ;
    endcase
    // wait for the squared deadzone to follow the write
    repeat (2) @(posedge clk_i);
  endtask

  task automatic reg_read_check(logic [1:0] idx, logic [31:0] exp_v);
    logic [31:0] got;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    got = prdata;
    psel <= 1'b0;
    penable <= 1'b0;
    check_field("register readback", exp_v, got);
    @(posedge clk_i);
  endtask

  task automatic set_config(logic [AxisW-1:0] cx, logic [AxisW-1:0] cy,
                            logic [DzW-1:0] dz);
    settle_block();
    reg_write(RegCenterX, 32'(cx));
    reg_write(RegCenterY, 32'(cy));
    reg_write(RegDeadzone, 32'(dz));
  endtask

  function automatic logic [AxisW-1:0] clamp_axis(int v);
    if (v < 0) return '0;
    if (v > 4095) return '1;
    return AxisW'(v);
  endfunction

  // unit circle in thousandths, index 0 is right, steps go clockwise
  function automatic int unit_cos(int d);
    case (d & 7)
      0: return 1000;
      1: return 707;
      2: return 0;
      3: return -707;
      4: return -1000;
      5: return -707;
      6: return 0;
      default: return 707;
    endcase
  endfunction

  // circle the stick around the center; strict means always one step clockwise
  task automatic sweep_stick(int frames, bit strict);
    int d;
    int r;
    int pick;
    d = $urandom_range(7);
    for (int k = 0; k < frames; k++) begin
      r = $urandom_range(1950, 900);
      send_item(OpFrame,
                clamp_axis(int'(cfg_cx) + r * unit_cos(d) / 1000 +
                           int'($urandom_range(40)) - 20),
                clamp_axis(int'(cfg_cy) + r * unit_cos(d + 6) / 1000 +
                           int'($urandom_range(40)) - 20),
                BtnW'($urandom_range(15)), 1'($urandom_range(1)));
      pick = $urandom_range(99);
      if (strict || pick < 60) d = d + 1;
      else if (pick < 75) d = d + 2;
      else if (pick < 85) d = d;
      else if (pick < 95) d = d + 7;
      else d = d + 3;
    end
  endtask

  // stick near the center, mostly inside the deadzone
  task automatic rest_stick(int frames);
    int spread;
    spread = int'(cfg_dz) / 2 + 1;
    for (int k = 0; k < frames; k++)
      send_item(OpFrame,
                clamp_axis(int'(cfg_cx) + int'($urandom_range(2 * spread)) - spread),
                clamp_axis(int'(cfg_cy) + int'($urandom_range(2 * spread)) - spread),
                BtnW'($urandom_range(15)), 1'($urandom_range(1)));
  endtask

  // take transactions carry junk in the ignored fields
  task automatic take_pulses(int count);
    for (int k = 0; k < count; k++)
      send_item(OpTake, AxisW'($urandom), AxisW'($urandom), BtnW'($urandom),
                1'($urandom));
  endtask

  task automatic random_mix(int count);
    int stop_at;
    int pick;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      pick = $urandom_range(99);
      if (pick < 45) sweep_stick($urandom_range(16, 4), 1'b0);
      else if (pick < 60) rest_stick($urandom_range(5, 1));
      else if (pick < 80) take_pulses($urandom_range(4, 1));
      else begin
        repeat ($urandom_range(3, 1))
          send_item(OpFrame, AxisW'($urandom), AxisW'($urandom), BtnW'($urandom),
                    1'($urandom));
      end
    end
  endtask

  // extremes of the fields, take with nothing pending, a clockwise turn,
  // pulses taken, then a rest long enough to forget the sector
  task automatic test_directed_cases();
    take_pulses(1);
    send_item(OpFrame, 12'h000, 12'h000, 4'h0, 1'b0);
    send_item(OpFrame, 12'hFFF, 12'hFFF, 4'hF, 1'b1);
    send_item(OpFrame, 12'hFFF, 12'h000, 4'hA, 1'b0);
    send_item(OpFrame, 12'h000, 12'hFFF, 4'h5, 1'b1);
    for (int d = 0; d < 4; d++)
      repeat (3)
        send_item(OpFrame, clamp_axis(2048 + 2047 * unit_cos(2 * d) / 1000),
                  clamp_axis(2048 + 2047 * unit_cos(2 * d + 6) / 1000), 4'h3, 1'b0);
    take_pulses(3);
    repeat (4) send_item(OpFrame, 12'd2048, 12'd2048, 4'h0, 1'b0);
  endtask

  // masking on write, readback, and a write to the unused slot
  task automatic test_register_access();
    settle_block();
    reg_write(RegCenterX, 32'hFFFF_FABC);
    reg_write(RegCenterY, 32'h1234_5321);
    reg_write(RegDeadzone, 32'hFFFF_FFFF);
    reg_write(RegUnused, 32'hFFFF_FFFF);
    reg_read_check(RegCenterX, 32'(cfg_cx));
    reg_read_check(RegCenterY, 32'(cfg_cy));
    reg_read_check(RegDeadzone, 32'(cfg_dz));
    sweep_stick(6, 1'b0);
  endtask

  // steady clockwise circling with a small deadzone drives the count to 255
  task automatic test_pulse_saturation();
    set_config(AxisMid, AxisMid, 11'd100);
    sweep_stick(300, 1'b1);
    take_pulses(12);
    rest_stick(4);
  endtask

  task automatic test_config_extremes();
    set_config(12'd0, 12'd4095, 11'd0);
    random_mix(50);
    set_config(12'd4095, 12'd0, 11'd2047);
    random_mix(50);
  endtask

  task automatic test_random_traffic(int count);
    set_config(AxisW'($urandom_range(2600, 1500)), AxisW'($urandom_range(2600, 1500)),
               DzW'($urandom_range(600, 0)));
    random_mix(count);
  endtask

  // receiver stalls for a long stretch while input keeps coming
  task automatic test_output_backpressure();
    hold_left <= HoldCycles;
    random_mix(60);
  endtask

  initial begin
    send_idle_pct = 16;
    recv_idle_pct = 76;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_register_access();
    test_pulse_saturation();
    test_config_extremes();
    test_random_traffic(170);

    send_idle_pct = 76;
    recv_idle_pct = 16;
    test_random_traffic(170);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(110);
    test_output_backpressure();

    settle_block();
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
